[rtl/lpg_pkg.sv]
// ---------------------------------------------------------------------------
// lpg_pkg: shared types and constants of the LED pattern generator
// Strip geometry, palette geometry, word layouts and the register map.
// ---------------------------------------------------------------------------
`default_nettype none

package lpg_pkg;

  // Strip and palette geometry (fixed by the field widths of the words)
  localparam int unsigned StripLength = 64;
  localparam int unsigned PosW        = 6;
  localparam int unsigned PaletteSize = 16;
  localparam int unsigned PalIdxW     = 4;
  localparam int unsigned CountW      = 5;
  localparam int unsigned RepeatW     = 16;
  localparam int unsigned StepW       = 16;
  localparam int unsigned ChanW       = 8;
  localparam int unsigned ColorW      = 3 * ChanW;

  // Stream word widths
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 32;

  // Configuration port
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CountW-1:0] ColorCountReset = CountW'(1);
  localparam logic [ChanW-1:0]  IntensityReset  = '1;

  typedef enum logic {
    OP_PALETTE_WRITE = 1'b0,
    OP_PIXEL         = 1'b1
  } op_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_COLOR_COUNT = 2'd0,
    CFG_CYCLIC_MODE = 2'd1,
    CFG_LEFT_START  = 2'd2,
    CFG_INTENSITY   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CountW-1:0] color_count;
    logic              cyclic_mode;
    logic              left_start;
    logic [ChanW-1:0]  intensity;
  } cfg_t;

  // Accepted input word, held in the input stage
  typedef struct packed {
    op_e                operation;
    logic [PalIdxW-1:0] entry_index;
    logic [ColorW-1:0]  color;      // red in the top byte
    logic [RepeatW-1:0] repeat_count;
    logic               frame_start;
    logic [StepW-1:0]   step;
  } item_t;

  // Per-pixel status from the sequencer
  typedef struct packed {
    logic [PosW-1:0] strip_pos;
    logic            lit;
    logic            last_pixel;
  } px_t;

endpackage

`default_nettype wire

[rtl/lpg_palette.sv]
// ---------------------------------------------------------------------------
// lpg_palette: palette color and repeat storage
// One write port from palette write words, one combinational read port
// addressed by the current color index. Entries are undefined until written.
// ---------------------------------------------------------------------------
`default_nettype none

module lpg_palette (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [lpg_pkg::PalIdxW-1:0]  waddr_i,
  input  wire logic [lpg_pkg::ColorW-1:0]   wcolor_i,
  input  wire logic [lpg_pkg::RepeatW-1:0]  wrepeat_i,
  input  wire logic [lpg_pkg::PalIdxW-1:0]  raddr_i,
  output logic      [lpg_pkg::ColorW-1:0]   rcolor_o,
  output logic      [lpg_pkg::RepeatW-1:0]  rrepeat_o
);

  logic [lpg_pkg::ColorW-1:0]  color_q  [lpg_pkg::PaletteSize];
  logic [lpg_pkg::RepeatW-1:0] repeat_q [lpg_pkg::PaletteSize];

  // Load one entry; the index field covers exactly the palette
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      color_q[waddr_i]  <= wcolor_i;
      repeat_q[waddr_i] <= wrepeat_i;
    end
  end

  assign rcolor_o  = color_q[raddr_i];
  assign rrepeat_o = repeat_q[raddr_i];

endmodule

`default_nettype wire

[rtl/lpg_sequencer.sv]
// ---------------------------------------------------------------------------
// lpg_sequencer: frame position and palette walk
// Holds position, color index, repeat progress, pixel count and the latched
// step; decides lit/unlit and the last-pixel flag for the current request.
// ---------------------------------------------------------------------------
`default_nettype none

module lpg_sequencer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         advance_i,
  input  wire logic                         frame_start_i,
  input  wire logic [lpg_pkg::StepW-1:0]    step_i,
  input  wire lpg_pkg::cfg_t                cfg_i,
  input  wire logic [lpg_pkg::RepeatW-1:0]  repeat_i,
  output logic      [lpg_pkg::PalIdxW-1:0]  run_idx_o,
  output lpg_pkg::px_t                      px_o
);

  localparam logic [lpg_pkg::PosW-1:0] LastPos = lpg_pkg::PosW'(lpg_pkg::StripLength - 1);
  localparam logic [lpg_pkg::CountW-1:0] MaxCount = lpg_pkg::CountW'(lpg_pkg::PaletteSize);

  logic [lpg_pkg::PosW-1:0]    position_q, position_d;
  logic [lpg_pkg::PalIdxW-1:0] run_idx_q, run_idx_d;
  logic [lpg_pkg::RepeatW-1:0] progress_q, progress_d;
  logic [lpg_pkg::PosW-1:0]    done_q, done_d;
  logic [lpg_pkg::PosW-1:0]    step_q, step_d;

  logic [lpg_pkg::PosW-1:0]    step_clamped;
  logic [lpg_pkg::PosW-1:0]    cur_pos;
  logic [lpg_pkg::PalIdxW-1:0] cur_ci;
  logic [lpg_pkg::RepeatW-1:0] cur_progress;
  logic [lpg_pkg::PosW-1:0]    cur_done;
  logic [lpg_pkg::CountW-1:0]  used_colors;
  logic [lpg_pkg::PosW-1:0]    far_dist;

  // Clamp an out-of-range step to zero at frame start
  assign step_clamped = (step_i > lpg_pkg::StepW'(lpg_pkg::StripLength - 1))
                      ? '0 : step_i[lpg_pkg::PosW-1:0];

  // Frame start restarts the walk on this very pixel
  always_comb begin
    if (frame_start_i) begin
      step_d       = step_clamped;
      cur_pos      = step_clamped;
      cur_ci       = '0;
      cur_progress = '0;
      cur_done     = '0;
    end else begin
      step_d       = step_q;
      cur_pos      = position_q;
      cur_ci       = run_idx_q;
      cur_progress = progress_q;
      cur_done     = done_q;
    end
  end

  // Usable color count: zero acts as one, cap at the palette size
  always_comb begin
    if (cfg_i.color_count == '0) begin
      used_colors = lpg_pkg::CountW'(1);
    end else if (cfg_i.color_count > MaxCount) begin
      used_colors = MaxCount;
    end else begin
      used_colors = cfg_i.color_count;
    end
  end

  // Advance the walk
  always_comb begin
    if (cur_progress >= repeat_i) begin
      run_idx_d  = (lpg_pkg::CountW'(cur_ci) < used_colors - lpg_pkg::CountW'(1))
                 ? cur_ci + lpg_pkg::PalIdxW'(1) : '0;
      progress_d = '0;
    end else begin
      run_idx_d  = cur_ci;
      progress_d = cur_progress + lpg_pkg::RepeatW'(1);
    end
    position_d = (cur_pos < LastPos) ? cur_pos + lpg_pkg::PosW'(1) : '0;
    done_d     = (cur_done < LastPos) ? cur_done + lpg_pkg::PosW'(1) : '0;
  end

  // Distance of the pixel from the far end
  assign far_dist = LastPos - cur_pos;

  assign run_idx_o       = cur_ci;
  assign px_o.strip_pos  = cur_pos;
  assign px_o.last_pixel = (cur_done == LastPos);
  assign px_o.lit        = cfg_i.cyclic_mode
                         || (cfg_i.left_start && (far_dist > step_d))
                         || (!cfg_i.left_start && (cur_pos > step_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q <= '0;
      run_idx_q  <= '0;
      progress_q <= '0;
      done_q     <= '0;
      step_q     <= '0;
    end else if (advance_i) begin
      position_q <= position_d;
      run_idx_q  <= run_idx_d;
      progress_q <= progress_d;
      done_q     <= done_d;
      step_q     <= step_d;
    end
  end

endmodule

`default_nettype wire

[rtl/lpg_scale.sv]
// ---------------------------------------------------------------------------
// lpg_scale: brightness scaling of one color channel
// Computes floor(chan * intensity / 255) with an exact reciprocal form.
// ---------------------------------------------------------------------------
`default_nettype none

module lpg_scale (
  input  wire logic [lpg_pkg::ChanW-1:0] chan_i,
  input  wire logic [lpg_pkg::ChanW-1:0] intensity_i,
  output logic      [lpg_pkg::ChanW-1:0] chan_o
);

  localparam int unsigned ProdW = 2 * lpg_pkg::ChanW;

  logic [ProdW-1:0] prod;
  logic [ProdW:0]   sum;

  // x / 255 == (x + 1 + (x >> 8)) >> 8 for every x up to 255 * 255
  assign prod   = ProdW'(chan_i) * ProdW'(intensity_i);
  assign sum    = (ProdW+1)'(prod) + (ProdW+1)'(1)
                + (ProdW+1)'(prod >> lpg_pkg::ChanW);
  assign chan_o = sum[lpg_pkg::ChanW +: lpg_pkg::ChanW];

endmodule

`default_nettype wire

[rtl/led_pattern_generator_core.sv]
// ---------------------------------------------------------------------------
// led_pattern_generator_core: palette-driven LED strip frame generator
// Palette write words load a color and repeat count; pixel request words
// return one scaled pixel color each, with tlast on the frame's last pixel.
// ---------------------------------------------------------------------------
//  channel  direction  contents
//  s_axis   in         tuser: operation; tdata: palette entry or pixel request
//  m_axis   out        tdata: pixel index and RGB; tlast: last pixel of frame
//  cfg      in         color count, cyclic mode, left start, intensity
//
//  One word per cycle in and out while m_axis is not stalled; a pixel request
//  passes the input stage, then the result register, before it shows on m_axis.
//  The palette read, walk update and channel multiply sit between the input
//  stage and the result register.
//  A stalled result holds in the output register; the input stage then takes
//  one more pixel word and holds it, while palette writes that reach the input
//  stage before it keep passing through without waiting on m_axis.
//  Reset clears the walk state and valid flags and loads the configuration
//  reset values; the palette is undefined until written.
// ---------------------------------------------------------------------------
`default_nettype none

module led_pattern_generator_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Input stream
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata: entry_index[3:0], red_in[11:4], green_in[19:12], blue_in[27:20],
  //        repeat_count[43:28], frame_start[44], step[60:45], zero[63:61]
  input  wire logic [lpg_pkg::InDataW-1:0]    s_axis_tdata_i,
  // tuser: operation[0]
  input  wire logic                           s_axis_tuser_i,
  // Output stream
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // tdata: pixel_index[5:0], red_out[13:6], green_out[21:14],
  //        blue_out[29:22], zero[31:30]
  output logic      [lpg_pkg::OutDataW-1:0]   m_axis_tdata_o,
  output logic                                m_axis_tlast_o,
  // Configuration writes
  input  wire logic                           cfg_we_i,
  input  wire logic [lpg_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  wire logic [lpg_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  lpg_pkg::cfg_t  cfg_q;
  lpg_pkg::item_t in_q, in_d;
  logic           in_valid_q;
  logic           advance;
  logic           adv_pixel;
  logic           adv_write;

  logic [lpg_pkg::PalIdxW-1:0] rd_idx;
  logic [lpg_pkg::ColorW-1:0]  rd_color;
  logic [lpg_pkg::RepeatW-1:0] rd_repeat;
  lpg_pkg::px_t                px;
  logic [lpg_pkg::ChanW-1:0]   red_s, green_s, blue_s;

  logic                        out_valid_q, out_valid_d;
  logic [lpg_pkg::PosW-1:0]    out_index_q;
  logic [lpg_pkg::ChanW-1:0]   out_red_q, out_green_q, out_blue_q;
  logic                        out_last_q;

  // Configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.color_count <= lpg_pkg::ColorCountReset;
      cfg_q.cyclic_mode <= 1'b0;
      cfg_q.left_start  <= 1'b0;
      cfg_q.intensity   <= lpg_pkg::IntensityReset;
    end else if (cfg_we_i) begin
      unique case (lpg_pkg::cfg_reg_e'(cfg_addr_i))
        lpg_pkg::CFG_COLOR_COUNT: cfg_q.color_count <= cfg_wdata_i[lpg_pkg::CountW-1:0];
        lpg_pkg::CFG_CYCLIC_MODE: cfg_q.cyclic_mode <= cfg_wdata_i[0];
        lpg_pkg::CFG_LEFT_START:  cfg_q.left_start  <= cfg_wdata_i[0];
        lpg_pkg::CFG_INTENSITY:   cfg_q.intensity   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Unpack the incoming word
  always_comb begin
    in_d.operation    = lpg_pkg::op_e'(s_axis_tuser_i);
    in_d.entry_index  = s_axis_tdata_i[3:0];
    in_d.color        = {s_axis_tdata_i[11:4], s_axis_tdata_i[19:12], s_axis_tdata_i[27:20]};
    in_d.repeat_count = s_axis_tdata_i[43:28];
    in_d.frame_start  = s_axis_tdata_i[44];
    in_d.step         = s_axis_tdata_i[60:45];
  end

  // Stage advance: writes always go, pixels need room in the result register
  assign adv_write = in_valid_q && (in_q.operation == lpg_pkg::OP_PALETTE_WRITE);
  assign adv_pixel = in_valid_q && (in_q.operation == lpg_pkg::OP_PIXEL)
                  && (!out_valid_q || m_axis_tready_i);
  assign advance   = adv_write || adv_pixel;
  assign s_axis_tready_o = !in_valid_q || advance;

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q <= in_d;
    end
  end

  lpg_palette u_palette (
    .clk_i     (clk_i),
    .we_i      (adv_write),
    .waddr_i   (in_q.entry_index),
    .wcolor_i  (in_q.color),
    .wrepeat_i (in_q.repeat_count),
    .raddr_i   (rd_idx),
    .rcolor_o  (rd_color),
    .rrepeat_o (rd_repeat)
  );

  lpg_sequencer u_sequencer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (adv_pixel),
    .frame_start_i (in_q.frame_start),
    .step_i        (in_q.step),
    .cfg_i         (cfg_q),
    .repeat_i      (rd_repeat),
    .run_idx_o     (rd_idx),
    .px_o          (px)
  );

  lpg_scale u_scale_red (
    .chan_i      (rd_color[2*lpg_pkg::ChanW +: lpg_pkg::ChanW]),
    .intensity_i (cfg_q.intensity),
    .chan_o      (red_s)
  );

  lpg_scale u_scale_green (
    .chan_i      (rd_color[lpg_pkg::ChanW +: lpg_pkg::ChanW]),
    .intensity_i (cfg_q.intensity),
    .chan_o      (green_s)
  );

  lpg_scale u_scale_blue (
    .chan_i      (rd_color[0 +: lpg_pkg::ChanW]),
    .intensity_i (cfg_q.intensity),
    .chan_o      (blue_s)
  );

  // Result register: load on a pixel advance, drop when taken
  always_comb begin
    if (adv_pixel) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_pixel) begin
      out_index_q <= px.strip_pos;
      out_red_q   <= px.lit ? red_s   : '0;
      out_green_q <= px.lit ? green_s : '0;
      out_blue_q  <= px.lit ? blue_s  : '0;
      out_last_q  <= px.last_pixel;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {2'b00, out_blue_q, out_green_q, out_red_q, out_index_q};

  // A pending pixel must not be overwritten while the result is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i && in_valid_q
     && (in_q.operation == lpg_pkg::OP_PIXEL)) |-> !s_axis_tready_o)
    else $error("input stage released while result register is stalled");

  // Palette writes never produce a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_write && !out_valid_q) |=> !out_valid_q)
    else $error("palette write produced a result");

  // A stalled result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> $stable(m_axis_tdata_o) && out_valid_q)
    else $error("stalled result changed");

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for led_pattern_generator_core
// Streams palette loads and pixel requests into the core, predicts every
// pixel word from a private copy of the palette and the frame walk, and
// compares each returned word field by field under random stalls on both
// streams.
// ---------------------------------------------------------------------------
module tb_top;
  import lpg_pkg::*;

  localparam int unsigned PhaseWords  = 85;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned DrainCycles = 8;

  typedef struct packed {
    logic [PosW-1:0]  index;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             last;
  } pixel_t;

  // Palette, frame walk and registers, plus the pixel words still owed
  class strip_scoreboard;
    logic [ColorW-1:0]  pal_color  [PaletteSize];
    logic [RepeatW-1:0] pal_repeat [PaletteSize];
    logic [PosW-1:0]    position;
    logic [PosW-1:0]    pixels_done;
    logic [PosW-1:0]    frame_step;
    logic [PalIdxW-1:0] run_idx;
    logic [RepeatW-1:0] repeat_progress;
    cfg_t               cfg;
    pixel_t             pending_pixels [$];
    int unsigned        errors;
    int unsigned        pixels_seen;
    int unsigned        palette_writes;
    int unsigned        frame_starts;

    function new();
      position          = '0;
      pixels_done       = '0;
      frame_step        = '0;
      run_idx           = '0;
      repeat_progress   = '0;
      cfg.color_count   = ColorCountReset;
      cfg.cyclic_mode   = 1'b0;
      cfg.left_start    = 1'b0;
      cfg.intensity     = IntensityReset;
      errors            = 0;
      pixels_seen       = 0;
      palette_writes    = 0;
      frame_starts      = 0;
    endfunction

    function void set_reg(cfg_reg_e addr, logic [CfgDataW-1:0] value);
      case (addr)
        CFG_COLOR_COUNT: cfg.color_count = value[CountW-1:0];
        CFG_CYCLIC_MODE: cfg.cyclic_mode = value[0];
        CFG_LEFT_START:  cfg.left_start  = value[0];
        CFG_INTENSITY:   cfg.intensity   = value;
        default: ;
      endcase
    endfunction

    function logic [ChanW-1:0] scale_chan(logic [ChanW-1:0] c);
      int unsigned prod;
      prod = int'(c) * int'(cfg.intensity);
      return ChanW'(prod / 255);
    endfunction

    // Note one accepted input word and queue the pixel it owes, if any
    function void take_word(op_e op, logic [InDataW-1:0] data);
      logic [PalIdxW-1:0] entry;
      logic [StepW-1:0]   step;
      int unsigned        n;
      logic               lit;
      logic [ColorW-1:0]  rgb;
      pixel_t             px;
      entry = data[3:0];
      if (op == OP_PALETTE_WRITE) begin
        pal_color[entry]  = {data[11:4], data[19:12], data[27:20]};
        pal_repeat[entry] = data[43:28];
        palette_writes++;
        return;
      end
      // Frame start: clamp an out-of-strip step to zero and restart the walk
      if (data[44]) begin
        step            = data[60:45];
        frame_step      = (step > StripLength - 1) ? '0 : step[PosW-1:0];
        position        = frame_step;
        run_idx         = '0;
        repeat_progress = '0;
        pixels_done     = '0;
        frame_starts++;
      end
      n = 32'(cfg.color_count);
      if (n == 0) n = 1;
      if (n > PaletteSize) n = PaletteSize;
      lit = cfg.cyclic_mode ||
            (cfg.left_start  && (StripLength - 1 - position) > frame_step) ||
            (!cfg.left_start && position > frame_step);
      rgb      = pal_color[run_idx];
      px.index = position;
      px.red   = lit ? scale_chan(rgb[23:16]) : '0;
      px.green = lit ? scale_chan(rgb[15:8])  : '0;
      px.blue  = lit ? scale_chan(rgb[7:0])   : '0;
      px.last  = (pixels_done == StripLength - 1);
      pending_pixels.push_back(px);
      // Advance color run, then position and frame count (both wrap at 64)
      if (repeat_progress >= pal_repeat[run_idx]) begin
        run_idx         = (run_idx < n - 1) ? run_idx + 1'b1 : '0;
        repeat_progress = '0;
      end else begin
        repeat_progress = repeat_progress + 1'b1;
      end
      position    = position + 1'b1;
      pixels_done = pixels_done + 1'b1;
    endfunction

    // Compare one returned pixel word against the oldest owed pixel
    function void check_pixel(logic [OutDataW-1:0] data, logic last);
      pixel_t      want;
      int unsigned want_f [5];
      int unsigned got_f  [5];
      string       names  [5];
      int          i;
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t ns: unrequested pixel word: expected none, got data %h last %b",
                 $time, data, last);
        return;
      end
      want   = pending_pixels.pop_front();
      names  = '{"strip_pos", "red_out", "green_out", "blue_out", "last_pixel"};
      want_f = '{want.index, want.red, want.green, want.blue, want.last};
      got_f  = '{data[5:0], data[13:6], data[21:14], data[29:22], last};
      for (i = 0; i < 5; i++) begin
        if (want_f[i] != got_f[i]) begin
          errors++;
          $display("%0t ns: pixel %0d %s: expected %0d, got %0d",
                   $time, pixels_seen, names[i], want_f[i], got_f[i]);
        end
      end
      pixels_seen++;
    endfunction
  endclass

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [InDataW-1:0]  in_data   = '0;
  logic                in_user   = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [OutDataW-1:0] out_data;
  logic                out_last;
  logic                cfg_we    = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr  = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  strip_scoreboard board;
  int unsigned     in_calm    = 0;
  int unsigned     out_calm   = 0;
  int unsigned     frame_left = 0;

  led_pattern_generator_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_user),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),
    .m_axis_tlast_o  (out_last),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  always #6 clk_i = ~clk_i;

  // Random wait before a word, with occasional runs of no waiting
  function automatic int unsigned draw_wait(inout int unsigned calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  function automatic logic [StepW-1:0] draw_step();
    case ($urandom_range(0, 9))
      0:       return StepW'($urandom);
      1:       return StepW'($urandom_range(60, 70));
      default: return StepW'($urandom_range(0, StripLength - 1));
    endcase
  endfunction

  // Mostly short color runs; a few long ones that park the palette walk
  function automatic logic [RepeatW-1:0] draw_repeat();
    case ($urandom_range(0, 9))
      8:       return RepeatW'($urandom_range(0, 40));
      9:       return RepeatW'($urandom);
      default: return RepeatW'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [InDataW-1:0] pack_word(logic [PalIdxW-1:0] entry,
                                                   logic [ColorW-1:0] rgb,
                                                   logic [RepeatW-1:0] rep,
                                                   logic start,
                                                   logic [StepW-1:0] step);
    return {3'b000, step, start, rep, rgb[7:0], rgb[15:8], rgb[23:16], entry};
  endfunction

  // Present one word and hold it until the core takes it
  task automatic send_word(input op_e op, input logic [InDataW-1:0] data);
    int unsigned gap;
    gap = draw_wait(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= data;
    in_user  <= op;
    do @(posedge clk_i); while (!in_ready);
    board.take_word(op, data);
  endtask

  // Frame fields of a palette word carry noise
  task automatic write_palette(input logic [PalIdxW-1:0] entry,
                               input logic [ColorW-1:0] rgb,
                               input logic [RepeatW-1:0] rep);
    send_word(OP_PALETTE_WRITE,
              pack_word(entry, rgb, rep, 1'($urandom), StepW'($urandom)));
  endtask

  // Palette fields of a pixel word carry noise
  task automatic request_pixel(input logic start, input logic [StepW-1:0] step);
    send_word(OP_PIXEL, pack_word(PalIdxW'($urandom), ColorW'($urandom),
                                  RepeatW'($urandom), start, step));
  endtask

  task automatic write_reg(input cfg_reg_e addr, input logic [CfgDataW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk_i);
    board.set_reg(addr, value);
  endtask

  // Drain owed pixels, then let trailing palette words clear the pipe
  task automatic settle();
    while (board.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Fixed corner settings first, random ones after
  task automatic load_settings(input int unsigned ph);
    logic [CfgDataW-1:0] cnt, cyc, lft, inten;
    case (ph)
      0: begin cnt = 8'd16; cyc = 8'd0; lft = 8'd0; inten = 8'd255; end
      1: begin cnt = 8'd0;  cyc = 8'd1; lft = 8'd0; inten = 8'd0;   end
      2: begin cnt = 8'd31; cyc = 8'd0; lft = 8'd1; inten = 8'd255; end
      3: begin cnt = 8'd1;  cyc = 8'd0; lft = 8'd1; inten = 8'd1;   end
      default: begin
        cnt   = CfgDataW'($urandom_range(0, 31));
        cyc   = CfgDataW'($urandom_range(0, 1));
        lft   = CfgDataW'($urandom_range(0, 1));
        inten = CfgDataW'($urandom_range(0, 255));
      end
    endcase
    write_reg(CFG_COLOR_COUNT, cnt);
    write_reg(CFG_CYCLIC_MODE, cyc);
    write_reg(CFG_LEFT_START, lft);
    write_reg(CFG_INTENSITY, inten);
    cfg_we <= 1'b0;
  endtask

  // Mostly whole frames; sprinkle palette loads, early restarts, rollovers
  task automatic random_word();
    if ($urandom_range(0, 9) == 0) begin
      write_palette(PalIdxW'($urandom), ColorW'($urandom), draw_repeat());
    end else if (frame_left == 0 || $urandom_range(0, 39) == 0) begin
      if (frame_left == 0 && $urandom_range(0, 7) == 0)
        request_pixel(1'b0, StepW'($urandom));
      else
        request_pixel(1'b1, draw_step());
      frame_left = StripLength - 1;
    end else begin
      request_pixel(1'b0, StepW'($urandom));
      frame_left--;
    end
  endtask

  // Stimulus and verdict
  initial begin
    int unsigned e;
    int unsigned ph;
    int unsigned k;
    board = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Load every entry so no pixel ever reads an empty slot
    for (e = 0; e < PaletteSize; e++) begin
      write_palette(PalIdxW'(e),
                    (e == 0) ? '1 : (e == 1) ? '0 : ColorW'($urandom),
                    (e == PaletteSize - 1) ? '1 : RepeatW'(e % 3));
    end
    // Pixel before any frame start, then step at the edge, past it and max
    request_pixel(1'b0, '0);
    request_pixel(1'b1, StepW'(StripLength - 1));
    request_pixel(1'b0, '1);
    request_pixel(1'b1, StepW'(StripLength));
    request_pixel(1'b1, '1);
    request_pixel(1'b1, '0);
    request_pixel(1'b0, '0);
    request_pixel(1'b1, StepW'(1));
    frame_left = StripLength - 2;

    for (ph = 0; ph < NumPhases; ph++) begin
      in_valid <= 1'b0;
      settle();
      load_settings(ph);
      for (k = 0; k < PhaseWords; k++) random_word();
    end
    in_valid <= 1'b0;
    settle();

    $display("Covered %0d pixel words over %0d frame starts and %0d palette loads,",
             board.pixels_seen, board.frame_starts, board.palette_writes);
    $display("across %0d register settings incl. zero and oversized color counts.",
             NumPhases + 1);
    if (board.errors == 0) begin
      $display("led_pattern_generator_core verification clean");
    end else begin
      $display("led_pattern_generator_core verification failed");
    end
    $finish;
  end

  // Output side: stall at random, check each word taken
  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = draw_wait(out_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      board.check_pixel(out_data, out_last);
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("led_pattern_generator_core verification failed");
    $finish;
  end

endmodule

[sim.f]
rtl/lpg_pkg.sv
rtl/lpg_palette.sv
rtl/lpg_sequencer.sv
rtl/lpg_scale.sv
rtl/led_pattern_generator_core.sv
sim/tb_top.sv
